FILE: rtl/square_wave_ramp_dac_sequencer_defines.svh
// assertion macros shared by the square-wave ramp dac sequencer rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef SQUARE_WAVE_RAMP_DAC_SEQUENCER_DEFINES_SVH
`define SQUARE_WAVE_RAMP_DAC_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF
`define SWR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SWR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWR_ASSERT(lbl, clk, rst, prop, msg)
`define SWR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: rtl/swrdac_pkg.sv
// types and constants for the square-wave ramp dac sequencer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package swrdac_pkg;

   localparam int FRAC_BITS    = 8;
   localparam int STEP_WIDTH   = 16;
   localparam int COARSE_W     = 6;
   localparam int FINE_W       = 12;
   localparam int DAC_W        = COARSE_W + FINE_W;
   localparam int CFG_W        = 21;
   localparam int RAMP_W       = 32;
   localparam int TOTAL_W      = RAMP_W + 2;
   localparam int COARSE_SHIFT = 6;      // coarse step is 64 fine codes
   localparam int FINE_MAX     = 4095;
   localparam int CSR_IDX_W    = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_START_COARSE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_COARSE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_STEP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_RAMP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_START   = 3'd5;

   typedef enum logic [1:0] {
      PH_START   = 2'd0,
      PH_FORWARD = 2'd1,
      PH_RETURN  = 2'd2,
      PH_STOP    = 2'd3
   } phase_type;

   typedef struct packed {
      logic [COARSE_W-1:0]     start_coarse;
      logic [COARSE_W-1:0]     peak_coarse;
      logic [STEP_WIDTH-1:0]   step_count;
      logic signed [CFG_W-1:0] code_per_step;
      logic signed [CFG_W-1:0] code_per_ramp;
      logic signed [CFG_W-1:0] ramp_start;
   } cfg_type;

   typedef struct packed {
      logic [DAC_W-1:0]    dac_word;
      logic [FINE_W-1:0]   fine_code;
      logic [COARSE_W-1:0] coarse_code;
      logic                sweep_done;
   } rsp_type;

endpackage

FILE: rtl/swrdac_csr.sv
// configuration registers of the square-wave ramp dac sequencer
// depends on swrdac_pkg
`timescale 1ns / 1ps

module swrdac_csr
   import swrdac_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_START_COARSE: cfg_in.start_coarse  = csr_write_data[COARSE_W-1:0];
            CSR_PEAK_COARSE:  cfg_in.peak_coarse   = csr_write_data[COARSE_W-1:0];
            CSR_STEP_COUNT:   cfg_in.step_count    = csr_write_data[STEP_WIDTH-1:0];
            CSR_CODE_STEP:    cfg_in.code_per_step = $signed(csr_write_data);
            CSR_CODE_RAMP:    cfg_in.code_per_ramp = $signed(csr_write_data);
            CSR_RAMP_START:   cfg_in.ramp_start    = $signed(csr_write_data);
            default:          cfg_in = cfg_ff;  // unmapped index is ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/swrdac_step.sv
// sweep state and per-tick ramp / dac word computation
// depends on swrdac_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "square_wave_ramp_dac_sequencer_defines.svh"

module swrdac_step
   import swrdac_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    step_en,
   input  logic    restart,
   output rsp_type result
);

   localparam logic [STEP_WIDTH-1:0] POS_MAX = '1;
   localparam logic signed [TOTAL_W-1:0] RAMP_HI =
      $signed({{(TOTAL_W-RAMP_W+1){1'b0}}, {(RAMP_W-1){1'b1}}});
   localparam logic signed [TOTAL_W-1:0] RAMP_LO =
      $signed({{(TOTAL_W-RAMP_W+1){1'b1}}, {(RAMP_W-1){1'b0}}});

   phase_type                phase_ff,  phase_in;
   logic [STEP_WIDTH-1:0]    pos_ff,    pos_in;
   logic                     wave_ff,   wave_in;
   logic signed [RAMP_W-1:0] ramp_ff,   ramp_in;
   logic [COARSE_W-1:0]      coarse_ff, coarse_in;

   phase_type                phase_cur;
   logic [STEP_WIDTH-1:0]    pos_cur;
   logic                     wave_cur;
   logic signed [RAMP_W-1:0] ramp_cur;

   logic signed [TOTAL_W-1:0] ramp_wide;
   logic signed [TOTAL_W-1:0] step_wide;
   logic signed [TOTAL_W-1:0] inc_wide;
   logic signed [CFG_W:0]     half_sum;
   logic signed [CFG_W:0]     half_step;
   logic signed [TOTAL_W-1:0] ramp_sum;
   logic signed [TOTAL_W-1:0] ramp_next_wide;
   logic [TOTAL_W-1:0]        coarse_term;
   logic signed [TOTAL_W-1:0] total;
   logic [TOTAL_W-1:0]        total_int;
   logic [FINE_W-1:0]         fine;

   // restart reloads the sweep before the tick is applied
   always_comb begin
      phase_cur = restart ? PH_START : phase_ff;
      pos_cur   = restart ? '0 : pos_ff;
      wave_cur  = restart ? 1'b0 : wave_ff;
      ramp_cur  = restart ? $signed({{(RAMP_W-CFG_W){cfg.ramp_start[CFG_W-1]}},
                                     cfg.ramp_start})
                          : ramp_ff;
   end

   always_comb begin
      phase_in  = phase_cur;
      coarse_in = coarse_ff;
      case (phase_cur)
         PH_START: begin
            coarse_in = cfg.start_coarse;
            phase_in  = PH_FORWARD;
         end
         PH_FORWARD: begin
            if (pos_cur >= (cfg.step_count >> 1)) begin
               coarse_in = cfg.peak_coarse;
               phase_in  = PH_RETURN;
            end
         end
         PH_RETURN: begin
            if (pos_cur >= cfg.step_count) begin
               phase_in = PH_STOP;
            end
         end
         default: phase_in = PH_STOP;
      endcase
   end

   // square wave on the staircase, saturated to 32 bits
   always_comb begin
      ramp_wide = $signed({{(TOTAL_W-RAMP_W){ramp_cur[RAMP_W-1]}}, ramp_cur});
      step_wide = $signed({{(TOTAL_W-CFG_W){cfg.code_per_step[CFG_W-1]}},
                           cfg.code_per_step});
      inc_wide  = $signed({{(TOTAL_W-CFG_W){cfg.code_per_ramp[CFG_W-1]}},
                           cfg.code_per_ramp});
      // halve rounding toward zero
      half_sum  = $signed({cfg.code_per_step[CFG_W-1], cfg.code_per_step})
                + $signed({{CFG_W{1'b0}}, cfg.code_per_step[CFG_W-1]});
      half_step = half_sum >>> 1;
      if (wave_cur) begin
         ramp_sum = ramp_wide - (step_wide - inc_wide);
      end else if (pos_cur == STEP_WIDTH'(1)) begin
         ramp_sum = ramp_wide
                  + $signed({{(TOTAL_W-CFG_W-1){half_step[CFG_W]}}, half_step});
      end else begin
         ramp_sum = ramp_wide + step_wide;
      end
      if (ramp_sum > RAMP_HI) begin
         ramp_next_wide = RAMP_HI;
      end else if (ramp_sum < RAMP_LO) begin
         ramp_next_wide = RAMP_LO;
      end else begin
         ramp_next_wide = ramp_sum;
      end
      ramp_in = ramp_next_wide[RAMP_W-1:0];
      wave_in = ~wave_cur;
      pos_in  = (pos_cur == POS_MAX) ? pos_cur : pos_cur + STEP_WIDTH'(1);
   end

   // compose coarse and fine codes
   always_comb begin
      coarse_term = TOTAL_W'(coarse_in) << (COARSE_SHIFT + FRAC_BITS);
      total       = $signed(coarse_term) + ramp_next_wide;
      total_int   = total >> FRAC_BITS;
      if (total[TOTAL_W-1]) begin
         fine = '0;
      end else if (total_int > TOTAL_W'(FINE_MAX)) begin
         fine = FINE_W'(FINE_MAX);
      end else begin
         fine = total_int[FINE_W-1:0];
      end
      result.dac_word    = {coarse_in, fine};
      result.fine_code   = fine;
      result.coarse_code = coarse_in;
      result.sweep_done  = (phase_in == PH_STOP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         pos_ff    <= '0;
         wave_ff   <= 1'b0;
         ramp_ff   <= '0;
         coarse_ff <= '0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         wave_ff   <= wave_in;
         ramp_ff   <= ramp_in;
         coarse_ff <= coarse_in;
      end
   end

   `SWR_ASSERT(a_stop_holds, clock, reset, (step_en && !restart && phase_ff == PH_STOP) |=> (phase_ff == PH_STOP), "stop phase left without restart")
   `SWR_ASSERT(a_pos_monotonic, clock, reset, (step_en && !restart) |=> (pos_ff >= $past(pos_ff)), "step position went backward")
   `SWR_ASSERT(a_wave_toggles, clock, reset, step_en |=> (wave_ff != $past(wave_cur)), "square wave did not toggle on a tick")

endmodule

FILE: rtl/square_wave_ramp_dac_sequencer.sv
// Square-wave ramp DAC sequencer: each accepted transaction is one DAC update tick and
// returns one composed coarse/fine DAC word. One transaction is accepted every clock
// cycle while req_stall is low; a result passes through the input register, then the
// state update and word composition into the result register. Back-pressure on rsp
// reaches req_stall only once both registers hold a transaction.
// depends on swrdac_pkg, swrdac_csr, swrdac_step and the assertion macro header
`timescale 1ns / 1ps
`include "square_wave_ramp_dac_sequencer_defines.svh"

module square_wave_ramp_dac_sequencer
   import swrdac_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_restart,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DAC_W-1:0]     rsp_dac_word,
   output logic [FINE_W-1:0]    rsp_fine_code,
   output logic [COARSE_W-1:0]  rsp_coarse_code,
   output logic                 rsp_sweep_done
);

   cfg_type cfg;
   rsp_type result;

   logic    in_valid_ff,   in_valid_in;
   logic    in_restart_ff;
   logic    rsp_valid_ff,  rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    out_free;
   logic    move;
   logic    req_take;

   swrdac_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   swrdac_step u_step (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (move),
      .restart (in_restart_ff),
      .result  (result)
   );

   always_comb begin
      out_free     = ~rsp_valid_ff | ~rsp_stall;
      move         = in_valid_ff & out_free;
      req_stall    = in_valid_ff & ~out_free;
      req_take     = req_valid & ~req_stall;
      in_valid_in  = req_take | (in_valid_ff & ~move);
      rsp_valid_in = move | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_restart_ff <= req_restart;
      end
      if (move) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_dac_word    = rsp_data_ff.dac_word;
   assign rsp_fine_code   = rsp_data_ff.fine_code;
   assign rsp_coarse_code = rsp_data_ff.coarse_code;
   assign rsp_sweep_done  = rsp_data_ff.sweep_done;

   `SWR_ASSERT(a_move_fills_rsp, clock, reset, move |=> rsp_valid_ff, "tick computed but no result held")
   `SWR_ASSERT(a_stall_only_full, clock, reset, req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall), "input stalled with room downstream")
   `SWR_ASSERT(a_rsp_held, clock, reset, (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)), "stalled result changed")

endmodule

FILE: bench/swrdac_checker.sv
// checker for the square-wave ramp dac sequencer: watches the csr port and both channels,
// predicts every dac word and compares it with the result channel
// depends on swrdac_pkg
`timescale 1ns / 1ps

module swrdac_checker
   import swrdac_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_write_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_restart,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [DAC_W-1:0]     rsp_dac_word,
   input  logic [FINE_W-1:0]    rsp_fine_code,
   input  logic [COARSE_W-1:0]  rsp_coarse_code,
   input  logic                 rsp_sweep_done,
   output int                   fail_count,
   output int                   pending_count
);

   localparam longint RAMP_HI = 64'sd2147483647;
   localparam longint RAMP_LO = -RAMP_HI - 1;

   // shadow copy of the registers and of the sweep state
   cfg_type               shadow_cfg;
   phase_type             phase_q;
   logic [STEP_WIDTH-1:0] step_pos_q;
   logic                  wave_high_q;
   longint                ramp_q;
   logic [COARSE_W-1:0]   coarse_q;

   rsp_type expected_words[$];

   function automatic longint clamp_ramp(input longint v);
      if (v > RAMP_HI) return RAMP_HI;
      if (v < RAMP_LO) return RAMP_LO;
      return v;
   endfunction

   // one dac update tick: phase, ramp, step position, then word composition
   function automatic rsp_type next_dac_word(input logic restart);
      rsp_type w;
      longint  step_amt;
      longint  ramp_amt;
      longint  total;
      longint  fine;
      step_amt = $signed(shadow_cfg.code_per_step);
      ramp_amt = $signed(shadow_cfg.code_per_ramp);
      if (restart) begin
         phase_q     = PH_START;
         step_pos_q  = '0;
         wave_high_q = 1'b0;
         ramp_q      = $signed(shadow_cfg.ramp_start);
      end
      case (phase_q)
         PH_START: begin
            coarse_q = shadow_cfg.start_coarse;
            phase_q  = PH_FORWARD;
         end
         PH_FORWARD: begin
            if (step_pos_q >= (shadow_cfg.step_count >> 1)) begin
               coarse_q = shadow_cfg.peak_coarse;
               phase_q  = PH_RETURN;
            end
         end
         PH_RETURN: begin
            if (step_pos_q >= shadow_cfg.step_count) phase_q = PH_STOP;
         end
         default: phase_q = PH_STOP;
      endcase
      if (wave_high_q) begin
         ramp_q      = clamp_ramp(ramp_q - (step_amt - ramp_amt));
         wave_high_q = 1'b0;
      end else begin
         // half step rounds toward zero
         if (step_pos_q == 1) ramp_q = clamp_ramp(ramp_q + step_amt / 2);
         else ramp_q = clamp_ramp(ramp_q + step_amt);
         wave_high_q = 1'b1;
      end
      if (step_pos_q != '1) step_pos_q = step_pos_q + 1'b1;
      total = (longint'(coarse_q) <<< (COARSE_SHIFT + FRAC_BITS)) + ramp_q;
      if (total < 0) begin
         fine = 0;
      end else begin
         fine = total >>> FRAC_BITS;
         if (fine > FINE_MAX) fine = FINE_MAX;
      end
      w.fine_code   = fine[FINE_W-1:0];
      w.coarse_code = coarse_q;
      w.dac_word    = {coarse_q, w.fine_code};
      w.sweep_done  = (phase_q == PH_STOP);
      return w;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : monitor
      rsp_type got;
      rsp_type want;
      if (reset) begin
         shadow_cfg  = '0;
         phase_q     = PH_START;
         step_pos_q  = '0;
         wave_high_q = 1'b0;
         ramp_q      = 0;
         coarse_q    = '0;
         fail_count  = 0;
         expected_words.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_START_COARSE: shadow_cfg.start_coarse  = csr_write_data[COARSE_W-1:0];
               CSR_PEAK_COARSE:  shadow_cfg.peak_coarse   = csr_write_data[COARSE_W-1:0];
               CSR_STEP_COUNT:   shadow_cfg.step_count    = csr_write_data[STEP_WIDTH-1:0];
               CSR_CODE_STEP:    shadow_cfg.code_per_step = csr_write_data;
               CSR_CODE_RAMP:    shadow_cfg.code_per_ramp = csr_write_data;
               CSR_RAMP_START:   shadow_cfg.ramp_start    = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_words.push_back(next_dac_word(req_restart));
         if (rsp_valid && !rsp_stall) begin
            got.dac_word    = rsp_dac_word;
            got.fine_code   = rsp_fine_code;
            got.coarse_code = rsp_coarse_code;
            got.sweep_done  = rsp_sweep_done;
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected result transaction", longint'(got.dac_word), 0);
            end else begin
               want = expected_words.pop_front();
               if (got.dac_word !== want.dac_word)
                  report_mismatch("dac_word", longint'(got.dac_word), longint'(want.dac_word));
               if (got.fine_code !== want.fine_code)
                  report_mismatch("fine_code", longint'(got.fine_code), longint'(want.fine_code));
               if (got.coarse_code !== want.coarse_code)
                  report_mismatch("coarse_code", longint'(got.coarse_code),
                                  longint'(want.coarse_code));
               if (got.sweep_done !== want.sweep_done)
                  report_mismatch("sweep_done", longint'(got.sweep_done),
                                  longint'(want.sweep_done));
            end
         end
      end
      pending_count <= expected_words.size();
   end

endmodule

FILE: bench/tb_top.sv
// top of the square-wave ramp dac sequencer bench: clock, reset, csr writes, tick stimulus,
// receiver stalls, watchdog and verdict
// depends on swrdac_pkg, swrdac_checker and the sequencer rtl
`timescale 1ns / 1ps

module tb_top;
   import swrdac_pkg::*;

   localparam int IDLE_LIMIT     = 3000;
   localparam int HOLDOFF_CYCLES = 240;
   localparam int TAIL_CYCLES    = 8;
   localparam int PHASE_ITEMS    = 200;

   // indexes past the register list, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [DAC_W-1:0]     rsp_dac_word;
   logic [FINE_W-1:0]    rsp_fine_code;
   logic [COARSE_W-1:0]  rsp_coarse_code;
   logic                 rsp_sweep_done;

   int fail_count;
   int pending_count;
   int sender_idle_pct = 0;
   int recv_idle_pct = 0;
   int holdoff_asked = 0;
   int holdoff_served = 0;
   int holdoff_left = 0;
   int idle_cycles = 0;

   cfg_type sweep_cfg;

   always #5 clock = ~clock;

   square_wave_ramp_dac_sequencer uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dac_word     (rsp_dac_word),
      .rsp_fine_code    (rsp_fine_code),
      .rsp_coarse_code  (rsp_coarse_code),
      .rsp_sweep_done   (rsp_sweep_done)
   );

   swrdac_checker dac_word_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dac_word     (rsp_dac_word),
      .rsp_fine_code    (rsp_fine_code),
      .rsp_coarse_code  (rsp_coarse_code),
      .rsp_sweep_done   (rsp_sweep_done),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left--;
      end else if (holdoff_served != holdoff_asked) begin
         holdoff_served = holdoff_asked;
         holdoff_left   = HOLDOFF_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("** square_wave_ramp_dac_sequencer: FAILED **");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance with valid still high
   task automatic send_tick(input logic restart);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   // dirty puts random bits above the narrow registers, junk adds writes past the list
   task automatic program_config(input cfg_type c, input bit dirty, input bit junk);
      logic [CFG_W-1:0] upper;
      upper = dirty ? CFG_W'($urandom) : '0;
      put_reg(CSR_START_COARSE, {upper[CFG_W-1:COARSE_W], c.start_coarse});
      put_reg(CSR_PEAK_COARSE, {upper[CFG_W-1:COARSE_W], c.peak_coarse});
      put_reg(CSR_STEP_COUNT, {upper[CFG_W-1:STEP_WIDTH], c.step_count});
      put_reg(CSR_CODE_STEP, c.code_per_step);
      put_reg(CSR_CODE_RAMP, c.code_per_ramp);
      put_reg(CSR_RAMP_START, c.ramp_start);
      if (junk) begin
         put_reg(CSR_UNUSED_LO, CFG_W'($urandom));
         put_reg(CSR_UNUSED_HI, '1);
      end
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [CFG_W-1:0] pick_q8();
      case ($urandom_range(7))
         0: return 21'h0FFFFF;
         1: return 21'h100000;
         2: return CFG_W'($urandom);
         default: return CFG_W'($urandom_range(0, 32767)) - CFG_W'(16384);
      endcase
   endfunction

   function automatic cfg_type random_sweep_cfg();
      cfg_type c;
      c.start_coarse = COARSE_W'($urandom);
      c.peak_coarse  = COARSE_W'($urandom);
      case ($urandom_range(9))
         0: c.step_count = '1;
         1: c.step_count = STEP_WIDTH'($urandom);
         default: c.step_count = STEP_WIDTH'($urandom_range(0, 40));
      endcase
      c.code_per_step = pick_q8();
      c.code_per_ramp = pick_q8();
      c.ramp_start    = ($urandom_range(3) == 0) ? pick_q8() : CFG_W'($urandom);
      return c;
   endfunction

   // mostly restart followed by a whole sweep when step_count is at most 40; sometimes noisy restarts all through
   task automatic run_sweep(output int n);
      int noise;
      if (sweep_cfg.step_count <= 40) n = sweep_cfg.step_count + $urandom_range(1, 6);
      else n = $urandom_range(1, 40);
      noise = ($urandom_range(9) == 0) ? 50 : 4;
      send_tick($urandom_range(9) != 0);
      for (int i = 1; i < n; i++) send_tick($urandom_range(99) < noise);
   endtask

   task automatic run_phase(input int snd, input int rcv, input bit hold);
      int sent;
      int n;
      sent = 0;
      sender_idle_pct = snd;
      recv_idle_pct   = rcv;
      if (hold) begin
         // keep offering transactions while the receiver holds off
         holdoff_asked++;
         repeat (30) send_tick(1'b0);
         sent = 30;
      end
      while (sent < PHASE_ITEMS) begin
         if ($urandom_range(9) < 4) begin
            wait_drained();
            sweep_cfg = random_sweep_cfg();
            program_config(sweep_cfg, $urandom_range(1) != 0, $urandom_range(3) == 0);
         end else if ($urandom_range(9) == 0) begin
            wait_drained();
         end
         run_sweep(n);
         sent += n;
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register reset values
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);

      // top coarse with the most negative ramp start: total goes negative and the fine code clips at zero
      wait_drained();
      sweep_cfg.start_coarse  = 6'd63;
      sweep_cfg.peak_coarse   = 6'd0;
      sweep_cfg.step_count    = 16'd4;
      sweep_cfg.code_per_step = 21'h0FFFFF;
      sweep_cfg.code_per_ramp = 21'h100000;
      sweep_cfg.ramp_start    = 21'h100000;
      program_config(sweep_cfg, 1'b1, 1'b1);
      send_tick(1'b1);
      repeat (6) send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);

      // zero step count: forward and return end at once and the sweep reaches stop
      wait_drained();
      sweep_cfg.start_coarse  = 6'd0;
      sweep_cfg.peak_coarse   = 6'd63;
      sweep_cfg.step_count    = 16'd0;
      sweep_cfg.code_per_step = 21'h100000;
      sweep_cfg.code_per_ramp = 21'h0FFFFF;
      sweep_cfg.ramp_start    = 21'h0FFFFF;
      program_config(sweep_cfg, 1'b0, 1'b0);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);

      wait_drained();
      sweep_cfg.start_coarse  = 6'd32;
      sweep_cfg.peak_coarse   = 6'd31;
      sweep_cfg.step_count    = 16'd1;
      sweep_cfg.code_per_step = 21'd768;
      sweep_cfg.code_per_ramp = 21'd256;
      sweep_cfg.ramp_start    = 21'h1FFF00;
      program_config(sweep_cfg, 1'b1, 1'b0);
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);

      run_phase(33, 76, 1'b0);
      run_phase(76, 33, 1'b1);
      run_phase(0, 0, 1'b1);

      // longest step count with the largest step and ramp: ramp climbs, fine code clips high
      wait_drained();
      sweep_cfg.start_coarse  = 6'd5;
      sweep_cfg.peak_coarse   = 6'd62;
      sweep_cfg.step_count    = '1;
      sweep_cfg.code_per_step = 21'h0FFFFF;
      sweep_cfg.code_per_ramp = 21'h0FFFFF;
      sweep_cfg.ramp_start    = '0;
      program_config(sweep_cfg, 1'b1, 1'b0);
      send_tick(1'b1);
      repeat (20) send_tick(1'b0);

      // most negative step and ramp: ramp falls, fine code clips at zero
      wait_drained();
      sweep_cfg.start_coarse  = 6'd63;
      sweep_cfg.peak_coarse   = 6'd0;
      sweep_cfg.step_count    = 16'd8;
      sweep_cfg.code_per_step = 21'h100000;
      sweep_cfg.code_per_ramp = 21'h100000;
      sweep_cfg.ramp_start    = 21'h0FFFFF;
      program_config(sweep_cfg, 1'b0, 1'b0);
      send_tick(1'b1);
      repeat (20) send_tick(1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** square_wave_ramp_dac_sequencer: PASSED **");
      end else begin
         $display("** square_wave_ramp_dac_sequencer: FAILED **");
      end
      $finish;
   end

endmodule
